// ----- src/tqle_pkg.sv -----
`default_nettype none

package tqle_pkg;

  localparam int STAGES     = 32;
  localparam int GRID_CELLS = 81;
  localparam int ROWS       = STAGES * GRID_CELLS;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int STAGE_W    = $clog2(STAGES);
  localparam int CELL_W     = $clog2(GRID_CELLS);

  // 0.01 in Q15.16, and one in Q15.16.
  localparam int STEP_COST = 655;
  localparam int ONE_Q16   = 65536;

  localparam logic [2:0] CFG_LEARN_RATE       = 3'd0;
  localparam logic [2:0] CFG_DISCOUNT         = 3'd1;
  localparam logic [2:0] CFG_EXPLORE_RATE     = 3'd2;
  localparam logic [2:0] CFG_SINGLE_STAGE     = 3'd3;
  localparam logic [2:0] CFG_STOP_ON_PROGRESS = 3'd4;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_ACT    = 1'b1;

  typedef logic signed [31:0] q_t;
  typedef logic [3:0][31:0]   row_t;

  typedef struct packed {
    logic        mode;
    logic [4:0]  stage;
    logic [6:0]  cell_req;
    logic [1:0]  move_taken;
    logic [6:0]  next_cell;
    logic        progress;
    logic        success;
    logic [15:0] explore_draw;
    logic [1:0]  random_move;
    logic [7:0]  tie_draw;
  } in_item_t;

  typedef struct packed {
    logic [1:0] chosen_move;
    logic       explored;
    q_t         entry_value;
  } out_item_t;

  typedef struct packed {
    logic [15:0] learn_rate;
    logic [15:0] discount;
    logic [15:0] explore_rate;
    logic        single_stage;
    logic        stop_on_progress;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic rd_next;
    logic rd_cur;
    logic cap_max;
    logic cap_row;
    logic mul_g;
    logic tgt;
    logic diff;
    logic mul_a;
    logic write;
    logic pick;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic clr_last;
  } status_t;

  // Saturates a 35-bit signed sum to the signed 32-bit range.
  function automatic q_t sat32(logic signed [34:0] x);
    if (x > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (x < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return q_t'(x);
  endfunction

  // Tie draw modulo a tie count of one to four. Since four is one modulo
  // three, the base-four digit sum keeps the remainder by three.
  function automatic logic [1:0] tie_index(logic [7:0] d, logic [2:0] n);
    logic [3:0] s;
    logic [1:0] r;
    s = 4'(d[1:0]) + 4'(d[3:2]) + 4'(d[5:4]) + 4'(d[7:6]);
    case (n)
      3'd2: r = {1'b0, d[0]};
      3'd3: begin
        if (s >= 4'd12) begin
          r = 2'd0;
        end else if (s >= 4'd9) begin
          r = 2'(s - 4'd9);
        end else if (s >= 4'd6) begin
          r = 2'(s - 4'd6);
        end else if (s >= 4'd3) begin
          r = 2'(s - 4'd3);
        end else begin
          r = 2'(s);
        end
      end
      3'd4: r = d[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/tqle_ctrl.sv -----
`default_nettype none

module tqle_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire tqle_pkg::status_t status,
  output tqle_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_NEXT,
    ST_MAX_N,
    ST_MULG,
    ST_TGT,
    ST_DIFF,
    ST_MULA,
    ST_WRITE,
    ST_RD_CUR,
    ST_MAX_C,
    ST_PICK
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.clr_step = (state == ST_CLEAR);
    cmd.rd_next  = (state == ST_RD_NEXT);
    cmd.rd_cur   = (state == ST_MAX_N) || (state == ST_RD_CUR);
    cmd.cap_max  = (state == ST_MAX_N) || (state == ST_MAX_C);
    cmd.cap_row  = (state == ST_MULG) || (state == ST_MAX_C);
    cmd.mul_g    = (state == ST_MULG);
    cmd.tgt      = (state == ST_TGT);
    cmd.diff     = (state == ST_DIFF);
    cmd.mul_a    = (state == ST_MULA);
    cmd.write    = (state == ST_WRITE) && out_free;
    cmd.pick     = (state == ST_PICK) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.write || cmd.pick) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (status.clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= (status.mode == tqle_pkg::MODE_ACT) ? ST_RD_CUR : ST_RD_NEXT;
          end
        end
        ST_RD_NEXT: state <= ST_MAX_N;
        ST_MAX_N:   state <= ST_MULG;
        ST_MULG:    state <= ST_TGT;
        ST_TGT:     state <= ST_DIFF;
        ST_DIFF:    state <= ST_MULA;
        ST_MULA:    state <= ST_WRITE;
        ST_WRITE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_RD_CUR: state <= ST_MAX_C;
        ST_MAX_C:  state <= ST_PICK;
        ST_PICK: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/tqle_datapath.sv -----
`default_nettype none

module tqle_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tqle_pkg::cmd_t      cmd,
  input  wire tqle_pkg::cfg_t      cfg,
  input  wire tqle_pkg::in_item_t  in_data,
  output tqle_pkg::status_t        status,
  output tqle_pkg::out_item_t      out_data
);

  localparam int ROW_W   = tqle_pkg::ROW_W;
  localparam int STAGE_W = tqle_pkg::STAGE_W;
  localparam int CELL_W  = tqle_pkg::CELL_W;

  tqle_pkg::row_t mem [tqle_pkg::ROWS];

  tqle_pkg::in_item_t item;
  tqle_pkg::row_t     rd_data;
  tqle_pkg::row_t     row;
  tqle_pkg::row_t     new_row;
  tqle_pkg::q_t       best;
  tqle_pkg::q_t       best_next;
  tqle_pkg::q_t       max01;
  tqle_pkg::q_t       max23;
  tqle_pkg::q_t       cur_v;
  tqle_pkg::q_t       target;
  tqle_pkg::q_t       new_v;
  logic signed [48:0] prod_g;
  logic signed [49:0] prod_a;
  logic signed [32:0] diff;
  logic signed [33:0] reward;
  logic signed [33:0] boot;
  logic signed [33:0] step;

  logic [ROW_W-1:0]   clr_cnt;
  logic [ROW_W-1:0]   row_cur;
  logic [ROW_W-1:0]   row_next;
  logic [ROW_W-1:0]   raddr;
  logic [ROW_W-1:0]   waddr;
  logic [STAGE_W-1:0] st_cur;
  logic [STAGE_W-1:0] st_next;
  logic [CELL_W-1:0]  cell_cur;
  logic [CELL_W-1:0]  cell_next;
  logic               drop_boot;
  logic               mem_we;
  logic               explore;
  logic [3:0]         eq;
  logic [2:0]         n_ties;
  logic [1:0]         tie_idx;
  logic [2:0]         k;
  logic [1:0]         pick;

  function automatic logic [STAGE_W-1:0] clamp_stage(logic [5:0] s, logic single);
    if (single) begin
      return '0;
    end
    if (32'(s) >= tqle_pkg::STAGES) begin
      return STAGE_W'(tqle_pkg::STAGES - 1);
    end
    return STAGE_W'(s);
  endfunction

  function automatic logic [CELL_W-1:0] clamp_cell(logic [6:0] c);
    if (32'(c) >= tqle_pkg::GRID_CELLS) begin
      return CELL_W'(tqle_pkg::GRID_CELLS - 1);
    end
    return CELL_W'(c);
  endfunction

  assign st_cur    = clamp_stage({1'b0, item.stage}, cfg.single_stage);
  assign st_next   = clamp_stage(6'(item.stage) + 6'(item.progress), cfg.single_stage);
  assign cell_cur  = clamp_cell(item.cell_req);
  assign cell_next = clamp_cell(item.next_cell);
  assign row_cur   = ROW_W'(st_cur) * ROW_W'(tqle_pkg::GRID_CELLS) + ROW_W'(cell_cur);
  assign row_next  = ROW_W'(st_next) * ROW_W'(tqle_pkg::GRID_CELLS) + ROW_W'(cell_next);
  assign raddr     = cmd.rd_next ? row_next : row_cur;

  assign status.mode     = in_data.mode;
  assign status.clr_last = (clr_cnt == ROW_W'(tqle_pkg::ROWS - 1));

  // Largest of the four action values in the row just read.
  assign max01     = ($signed(rd_data[0]) >= $signed(rd_data[1])) ? rd_data[0] : rd_data[1];
  assign max23     = ($signed(rd_data[2]) >= $signed(rd_data[3])) ? rd_data[2] : rd_data[3];
  assign best_next = (max01 >= max23) ? max01 : max23;

  assign drop_boot = item.success || (cfg.stop_on_progress && item.progress);
  assign reward    = item.progress ? 34'(tqle_pkg::ONE_Q16 - tqle_pkg::STEP_COST)
                                   : -34'(tqle_pkg::STEP_COST);
  assign boot      = drop_boot ? 34'sd0 : 34'($signed(prod_g[48:16]));
  assign step      = prod_a[49:16];
  assign new_v     = tqle_pkg::sat32(35'(cur_v) + 35'(step));

  always_comb begin
    new_row = row;
    new_row[item.move_taken] = new_v;
  end

  // Greedy choice: the tie draw selects among equal best entries in
  // ascending action order.
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      eq[a] = ($signed(row[a]) == best);
    end
    n_ties  = 3'($countones(eq));
    tie_idx = tqle_pkg::tie_index(item.tie_draw, n_ties);
    k       = 3'd0;
    pick    = 2'd0;
    for (int a = 0; a < 4; a++) begin
      if (eq[a]) begin
        if (k == {1'b0, tie_idx}) begin
          pick = 2'(a);
        end
        k = k + 3'd1;
      end
    end
  end

  assign explore = (item.explore_draw < cfg.explore_rate);

  assign mem_we = cmd.clr_step || cmd.write;
  assign waddr  = cmd.clr_step ? clr_cnt : row_cur;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= cmd.clr_step ? '0 : new_row;
    end
    if (cmd.rd_next || cmd.rd_cur) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.cap_max) begin
      best <= best_next;
    end
    if (cmd.cap_row) begin
      row   <= rd_data;
      cur_v <= rd_data[item.move_taken];
    end
    if (cmd.mul_g) begin
      prod_g <= best * $signed({1'b0, cfg.discount}) + 49'sd32768;
    end
    if (cmd.tgt) begin
      target <= tqle_pkg::sat32(35'(reward) + 35'(boot));
    end
    if (cmd.diff) begin
      diff <= 33'(target) - 33'(cur_v);
    end
    if (cmd.mul_a) begin
      prod_a <= diff * $signed({1'b0, cfg.learn_rate}) + 50'sd32768;
    end
    if (cmd.write) begin
      out_data.chosen_move <= item.move_taken;
      out_data.explored    <= 1'b0;
      out_data.entry_value <= new_v;
    end else if (cmd.pick) begin
      out_data.chosen_move <= explore ? item.random_move : pick;
      out_data.explored    <= explore;
      out_data.entry_value <= best;
    end
  end

endmodule

`default_nettype wire

// ----- src/tabular_q_learning_engine_core.sv -----
`default_nettype none

// Tabular Q-learning engine with one Q15.16 value table of STAGES x GRID_CELLS
// rows, each row holding the four action values side by side in one
// memory word. After reset a clearing pass writes one row per cycle, so
// in_ready stays low until all STAGES*GRID_CELLS rows (2592 at the default
// size) are cleared; configuration writes are taken throughout. Items are
// handled one at a time: an act item goes through the read, best value and
// pick before the next acceptance, an update item through two row reads for
// the bootstrap maximum and the old entry, then the discount multiply,
// target, difference, learn-rate multiply and write-back in turn. A finished
// result sits in the output register while the next item is accepted; the
// block stalls only at its last step if that result has not been taken yet.
module tabular_q_learning_engine_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tqle_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tqle_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  tqle_pkg::cfg_t    cfg;
  tqle_pkg::cmd_t    cmd;
  tqle_pkg::status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learn_rate       <= 16'd19661;
      cfg.discount         <= 16'd64225;
      cfg.explore_rate     <= 16'd13107;
      cfg.single_stage     <= 1'b0;
      cfg.stop_on_progress <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tqle_pkg::CFG_LEARN_RATE:       cfg.learn_rate       <= cfg_data;
        tqle_pkg::CFG_DISCOUNT:         cfg.discount         <= cfg_data;
        tqle_pkg::CFG_EXPLORE_RATE:     cfg.explore_rate     <= cfg_data;
        tqle_pkg::CFG_SINGLE_STAGE:     cfg.single_stage     <= cfg_data[0];
        tqle_pkg::CFG_STOP_ON_PROGRESS: cfg.stop_on_progress <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tqle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tqle_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

  // The clearing pass follows every reset, so no beat is taken straight after.
  assert property (@(posedge clk) $fell(rst) |-> !in_ready)
    else $error("input accepted before the table was cleared");

  // Items are processed one at a time.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted while an item is in progress");

  // The table is only written by the clearing pass or a write-back, never while idle.
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !(cmd.write || cmd.clr_step))
    else $error("table written while idle");

endmodule

`default_nettype wire
